// ===== sv/vdi_pkg.sv =====
// ============================================================================
// vdi_pkg - vertex dedup indexer shared definitions
// Table size, index widths, item/result payload types and the beat that
// travels along the row of compare cells.
// ============================================================================
package vdi_pkg;

    // table geometry
    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int NUM_WORDS   = 8;
    localparam int WORD_W      = 32;
    localparam int OUT_IDX_W   = 10;

    // one vertex, as accepted on the input side
    typedef struct packed {
        logic              start_mesh;
        logic [WORD_W-1:0] pos_x;
        logic [WORD_W-1:0] pos_y;
        logic [WORD_W-1:0] pos_z;
        logic [WORD_W-1:0] tex_u;
        logic [WORD_W-1:0] tex_v;
        logic [WORD_W-1:0] norm_x;
        logic [WORD_W-1:0] norm_y;
        logic [WORD_W-1:0] norm_z;
    } item_t;

    // one lookup result
    typedef struct packed {
        logic [OUT_IDX_W-1:0] out_index;
        logic                 is_new;
        logic                 table_full;
    } result_t;

    // compare beat handed from cell to cell
    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
        logic             match;
    } beat_t;

    // append control broadcast to every cell
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
    } wr_t;

    // low bits of a table index as seen on the result port
    function automatic logic [OUT_IDX_W-1:0] to_out_index(input logic [IDX_W-1:0] i);
        logic [31:0] wide;
        wide = 32'(i);
        return wide[OUT_IDX_W-1:0];
    endfunction

endpackage

// ===== sv/vdi_ram.sv =====
// ============================================================================
// vdi_ram - generic single write, single read RAM
// One write port and one read port; read data is registered.
// ============================================================================
module vdi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/vdi_cell.sv =====
// ============================================================================
// vdi_cell - one compare cell of the lookup row
// Holds one attribute word of every table entry. Each cycle it takes a beat
// from its left neighbor, reads its word of that entry, and hands the beat on
// with the match flag narrowed by its own word compare.
// ============================================================================
module vdi_cell
    import vdi_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [WORD_W-1:0] word,
    input  wr_t               wr,
    input  beat_t             beat_in,
    output beat_t             beat_out
);

    logic              valid_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic              match_reg;
    logic [WORD_W-1:0] rdata;

    // this cell's word of every entry
    vdi_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (wr.en),
        .waddr (wr.addr),
        .wdata (word),
        .raddr (beat_in.idx),
        .rdata (rdata)
    );

    // beat valid tracks the read in flight
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= beat_in.valid;
        end
    end

    // beat payload alongside the read
    always_ff @(posedge clk)
    begin
        idx_reg   <= beat_in.idx;
        match_reg <= beat_in.match;
    end

    // narrow the match with this cell's word
    always_comb
    begin
        beat_out.valid = valid_reg;
        beat_out.idx   = idx_reg;
        beat_out.match = match_reg && (rdata == word);
    end

endmodule

// ===== sv/vertex_dedup_indexer.sv =====
// ============================================================================
// vertex_dedup_indexer - indexed vertex buffer deduplication
// Looks up each vertex in the table of distinct vertices of the current mesh
// and returns the index of the equal entry, or appends it as a new entry.
// ============================================================================
// A vertex is taken when start is high and busy is low. Its eight attribute
// words are compared bit for bit against stored entries, one entry per cycle,
// by a row of eight cells, each holding one attribute word of every entry in
// its own RAM; the entry index enters the first cell and the match flag is
// narrowed cell by cell. The scan stops issuing at the first equal entry.
// Entries issued into the row are all stored entries on a miss; on a hit,
// the hit index plus eight of them, capped at the entry count, since the
// seven entries behind the hit are already in the eight cell stages when
// it shows; they drain before done. Exactly one result beat follows each
// item, shown on result for the single cycle done is high; it cannot be
// held off, and busy is already low in that cycle. start_mesh empties the
// table before the vertex is looked up; the table needs no clearing pass
// after reset. When the table is full a new vertex is not stored and
// table_full is reported.
// ============================================================================
module vertex_dedup_indexer
    import vdi_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  item_t   item,
    output logic    done,
    output result_t result
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic             state_reg,     state_next;
    item_t            item_reg,      item_next;
    logic [CNT_W-1:0] count_reg,     count_next;
    logic [CNT_W-1:0] issue_idx_reg, issue_idx_next;
    logic             hit_reg,       hit_next;
    logic [IDX_W-1:0] hit_idx_reg,   hit_idx_next;
    logic             done_reg,      done_next;
    result_t          result_reg,    result_next;

    logic              accept;
    logic              issue;
    logic              any_valid;
    logic              tail_hit;
    logic              finish;
    wr_t               wr;
    beat_t             beat [NUM_WORDS+1];
    logic [WORD_W-1:0] words [NUM_WORDS];

    // attribute words of the held vertex, one per cell
    assign words[0] = item_reg.pos_x;
    assign words[1] = item_reg.pos_y;
    assign words[2] = item_reg.pos_z;
    assign words[3] = item_reg.tex_u;
    assign words[4] = item_reg.tex_v;
    assign words[5] = item_reg.norm_x;
    assign words[6] = item_reg.norm_y;
    assign words[7] = item_reg.norm_z;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);

    // scan issue and hit detection at the end of the row
    assign tail_hit = beat[NUM_WORDS].valid && beat[NUM_WORDS].match && !hit_reg;
    assign issue    = (state_reg == ST_SCAN) && (issue_idx_reg < count_reg)
                      && !hit_reg && !tail_hit;

    always_comb
    begin
        any_valid = 1'b0;
        for (int k = 1; k <= NUM_WORDS; k++)
        begin
            any_valid = any_valid | beat[k].valid;
        end
    end

    assign finish = (state_reg == ST_SCAN) && !issue && !any_valid;

    // head beat of the row
    always_comb
    begin
        beat[0].valid = issue;
        beat[0].idx   = issue_idx_reg[IDX_W-1:0];
        beat[0].match = 1'b1;
    end

    // append on a miss with room left
    always_comb
    begin
        wr.en   = finish && !hit_reg && (count_reg < CNT_W'(TABLE_DEPTH));
        wr.addr = count_reg[IDX_W-1:0];
    end

    // row of compare cells
    for (genvar g = 0; g < NUM_WORDS; g++)
    begin : g_cell
        vdi_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .word     (words[g]),
            .wr       (wr),
            .beat_in  (beat[g]),
            .beat_out (beat[g+1])
        );
    end

    // control next state
    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        count_next     = count_reg;
        issue_idx_next = issue_idx_reg;
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        done_next      = 1'b0;
        result_next    = result_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    item_next      = item;
                    issue_idx_next = '0;
                    hit_next       = 1'b0;
                    state_next     = ST_SCAN;
                    if (item.start_mesh)
                    begin
                        count_next = '0;
                    end
                end
            end
            ST_SCAN:
            begin
                if (issue)
                begin
                    issue_idx_next = issue_idx_reg + CNT_W'(1);
                end
                if (tail_hit)
                begin
                    hit_next     = 1'b1;
                    hit_idx_next = beat[NUM_WORDS].idx;
                end
                if (finish)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                    if (hit_reg)
                    begin
                        result_next.out_index  = to_out_index(hit_idx_reg);
                        result_next.is_new     = 1'b0;
                        result_next.table_full = 1'b0;
                    end
                    else if (count_reg < CNT_W'(TABLE_DEPTH))
                    begin
                        result_next.out_index  = to_out_index(count_reg[IDX_W-1:0]);
                        result_next.is_new     = 1'b1;
                        result_next.table_full = 1'b0;
                        count_next             = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        result_next.out_index  = '0;
                        result_next.is_new     = 1'b0;
                        result_next.table_full = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            issue_idx_reg <= '0;
            hit_reg       <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            issue_idx_reg <= issue_idx_next;
            hit_reg       <= hit_next;
            done_reg      <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        item_reg    <= item_next;
        hit_idx_reg <= hit_idx_next;
        result_reg  <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // row is empty whenever the block is idle
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> !any_valid)
        else $error("compare beat in flight while idle");

    // entry count never passes the table size
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table size");

    // a new entry goes with exactly one count step
    a_new_counts: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.is_new |-> count_reg == CNT_W'($past(count_reg) + CNT_W'(1)))
        else $error("new entry without count step");

    // full report never claims a stored vertex
    a_full_not_new: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.table_full |-> !result.is_new && (result.out_index == '0))
        else $error("table full result marked new");

    // one beat per item, never two in a row
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for two cycles");

endmodule
